/* design/fplc_pkg.sv */
// package for the frame plane layout calculator
// holds format, operation and alignment codes, the request types and the divide helpers
// no dependencies
package fplc_pkg;

	// operation codes
	localparam logic OP_NORMAL = 1'b0;
	localparam logic OP_RAW    = 1'b1;

	// pixel format codes
	localparam logic [3:0] FMT_NV12    = 4'd0;
	localparam logic [3:0] FMT_NV21    = 4'd1;
	localparam logic [3:0] FMT_RGB565  = 4'd2;
	localparam logic [3:0] FMT_RGB888  = 4'd3;
	localparam logic [3:0] FMT_BAYER8  = 4'd4;
	localparam logic [3:0] FMT_BAYER10 = 4'd5;
	localparam logic [3:0] FMT_BAYER12 = 4'd6;
	localparam logic [3:0] FMT_BAYER14 = 4'd7;
	localparam logic [3:0] FMT_RAW10P  = 4'd8;
	localparam logic [3:0] FMT_UYVY    = 4'd9;
	localparam logic [3:0] FMT_YUYV    = 4'd10;
	localparam logic [3:0] FMT_YVYU    = 4'd11;
	localparam logic [3:0] FMT_VYUY    = 4'd12;

	// stride alignment select codes
	localparam logic [1:0] ALIGN_DEFAULT = 2'd0;
	localparam logic [1:0] ALIGN_SIXTEEN = 2'd1;
	localparam logic [1:0] ALIGN_THIRTY2 = 2'd2;
	localparam logic [1:0] ALIGN_SIXTY4  = 2'd3;

	localparam logic [6:0] ALIGN_VAL_16 = 7'd16;
	localparam logic [6:0] ALIGN_VAL_32 = 7'd32;
	localparam logic [6:0] ALIGN_VAL_64 = 7'd64;

	// dwt geometry
	localparam int DWT_LEVELS     = 4;
	localparam int DWT_PAGE_BITS  = 12;
	localparam int DWT_W_ALIGN    = 64;
	localparam int DWT_H_ALIGN    = 32;

	// reciprocals for ceiling division by 12 and 10, scaled by 2^19
	localparam int          RECIP_SHIFT = 19;
	localparam logic [16:0] RECIP_12    = 17'd43691;
	localparam logic [16:0] RECIP_10    = 17'd52429;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// status and classification carried with each request
	typedef struct packed {
		logic        status;
		logic [1:0]  planes;
		logic [15:0] s0;
		logic [15:0] s1;
		logic [6:0]  al;
		logic        nv;
	} fplc_meta_t;

	// classified request handed from front to back
	typedef struct packed {
		fplc_meta_t  meta;
		logic [13:0] height;
		logic [14:0] aw0;
		logic [14:0] ah0;
	} fplc_req_t;

	// ceil(w / 12) through a reciprocal multiply, exact for 14-bit w
	function automatic logic [10:0] ceil_div12(input logic [13:0] w);
		logic [14:0] x;
		logic [31:0] prod;
		x    = {1'b0, w} + 15'd11;
		prod = {17'd0, x} * {15'd0, RECIP_12};
		return prod[RECIP_SHIFT +: 11];
	endfunction

	// ceil(w / 10) through a reciprocal multiply, exact for 14-bit w
	function automatic logic [10:0] ceil_div10(input logic [13:0] w);
		logic [14:0] x;
		logic [31:0] prod;
		x    = {1'b0, w} + 15'd9;
		prod = {17'd0, x} * {15'd0, RECIP_10};
		return prod[RECIP_SHIFT +: 11];
	endfunction

endpackage

/* design/fplc_front.sv */
// front end of the frame plane layout calculator
// classifies a request and works out strides, alignment and dwt base sizes
// depends on fplc_pkg
module fplc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                operation,
	input  logic [3:0]          pixel_format,
	input  logic [1:0]          align_select,
	input  logic [13:0]         width,
	input  logic [13:0]         height,
	output logic                req_valid,
	input  logic                req_stall,
	output fplc_pkg::fplc_req_t req
);

	logic                valid_s1;
	fplc_pkg::fplc_req_t req_s1;
	fplc_pkg::fplc_req_t req_d;
	logic [6:0]          al;
	logic [14:0]         al_mask;
	logic [14:0]         stride;
	logic [12:0]         quad;
	logic [15:0]         raw10p_stride;
	logic                enable;

	// classification and stride arithmetic
	always_comb begin
		req_d = '0;
		case (align_select)
			fplc_pkg::ALIGN_THIRTY2: al = fplc_pkg::ALIGN_VAL_32;
			fplc_pkg::ALIGN_SIXTY4:  al = fplc_pkg::ALIGN_VAL_64;
			default:                 al = fplc_pkg::ALIGN_VAL_16;
		endcase
		al_mask       = 15'(al) - 15'd1;
		stride        = ({1'b0, width} + al_mask) & ~al_mask;
		quad          = 13'(({1'b0, width} + 15'd3) >> 2);
		raw10p_stride = {1'b0, quad, 2'b00} + {3'b000, quad};

		req_d.height     = height;
		req_d.aw0        = ({1'b0, width} + 15'(fplc_pkg::DWT_W_ALIGN - 1))
			& ~15'(fplc_pkg::DWT_W_ALIGN - 1);
		req_d.ah0        = ({1'b0, height} + 15'(fplc_pkg::DWT_H_ALIGN - 1))
			& ~15'(fplc_pkg::DWT_H_ALIGN - 1);
		req_d.meta.planes = 2'd1;

		if (operation == fplc_pkg::OP_NORMAL) begin
			req_d.meta.al = al;
			case (pixel_format) inside
				fplc_pkg::FMT_NV12, fplc_pkg::FMT_NV21: begin
					req_d.meta.planes = 2'd2;
					req_d.meta.s0     = 16'(stride);
					req_d.meta.s1     = 16'(stride);
					req_d.meta.nv     = 1'b1;
				end
				fplc_pkg::FMT_RGB565, fplc_pkg::FMT_BAYER10, fplc_pkg::FMT_BAYER12,
				fplc_pkg::FMT_BAYER14, [fplc_pkg::FMT_UYVY:fplc_pkg::FMT_VYUY]: begin
					req_d.meta.s0 = {stride, 1'b0};
				end
				fplc_pkg::FMT_RGB888: begin
					req_d.meta.s0 = {1'b0, stride} + {stride, 1'b0};
				end
				fplc_pkg::FMT_BAYER8: begin
					req_d.meta.s0 = {1'b0, stride};
				end
				fplc_pkg::FMT_RAW10P: begin
					req_d.meta.s0 = raw10p_stride;
				end
				default: begin
					req_d.meta.status = 1'b1;
				end
			endcase
		end else begin
			case (pixel_format)
				fplc_pkg::FMT_BAYER8:  req_d.meta.s0 = {2'b00, width};
				fplc_pkg::FMT_BAYER10: req_d.meta.s0 = {1'b0, fplc_pkg::ceil_div12(width), 4'b0000};
				fplc_pkg::FMT_BAYER12: req_d.meta.s0 = {1'b0, fplc_pkg::ceil_div10(width), 4'b0000};
				fplc_pkg::FMT_BAYER14: req_d.meta.s0 = {1'b0, width, 1'b0};
				fplc_pkg::FMT_RAW10P:  req_d.meta.s0 = raw10p_stride;
				default:               req_d.meta.status = 1'b1;
			endcase
		end

		// unsupported format clears every other result field
		if (req_d.meta.status) begin
			req_d.meta.planes = 2'd0;
			req_d.meta.s0     = '0;
			req_d.meta.s1     = '0;
			req_d.meta.al     = '0;
			req_d.meta.nv     = 1'b0;
		end
	end

	assign enable   = !valid_s1 || !req_stall;
	assign in_stall = !enable;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (enable) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (enable && in_valid) begin
			req_s1 <= req_d;
		end
	end

	assign req_valid = valid_s1;
	assign req       = req_s1;

endmodule

/* design/fplc_queue.sv */
// short request queue between the front and back ends
// register array with read and write pointers and a fill count
// depends on fplc_pkg
module fplc_queue #(
	parameter int DEPTH = fplc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_stall,
	input  fplc_pkg::fplc_req_t wr_req,
	output logic                rd_valid,
	input  logic                rd_stall,
	output fplc_pkg::fplc_req_t rd_req
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	fplc_pkg::fplc_req_t mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                full;
	logic                push;
	logic                pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign wr_stall = full;
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && !full;
	assign pop      = rd_valid && !rd_stall;
	assign rd_req   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_req;
		end
	end

endmodule

/* design/fplc_back.sv */
// back end of the frame plane layout calculator
// four stages: plane and dwt products, page alignment, partial sums, final total
// depends on fplc_pkg
module fplc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  fplc_pkg::fplc_req_t req,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                status,
	output logic [1:0]          plane_count,
	output logic [15:0]         first_stride,
	output logic [15:0]         second_stride,
	output logic [31:0]         first_size,
	output logic [31:0]         second_size,
	output logic [31:0]         total_size,
	output logic [6:0]          align_used
);

	localparam int NL = fplc_pkg::DWT_LEVELS;
	localparam int PB = fplc_pkg::DWT_PAGE_BITS;

	logic enable;

	// stage 1 signals
	logic                 valid_s1;
	fplc_pkg::fplc_meta_t meta_s1;
	logic [29:0]          z0_s1;
	logic [28:0]          prod_s1 [2*NL];
	logic [28:0]          prod_d  [2*NL];
	logic [13:0]          aw      [NL];
	logic [17:0]          aw10    [NL];
	logic [14:0]          pw      [NL];
	logic [13:0]          ah      [NL];
	logic [13:0]          ahc     [NL];

	// stage 2 signals
	logic                 valid_s2;
	fplc_pkg::fplc_meta_t meta_s2;
	logic [29:0]          z0_s2;
	logic [29:0]          z1_s2;
	logic [29:0]          pair_s2 [NL];
	logic [29:0]          pair_d  [NL];
	logic [28:0]          page    [2*NL];
	logic [29:0]          z1_d;

	// stage 3 signals
	logic                 valid_s3;
	fplc_pkg::fplc_meta_t meta_s3;
	logic [29:0]          z0_s3;
	logic [29:0]          z1_s3;
	logic [30:0]          quad_s3 [2];

	// output stage
	logic                 valid_s4;
	fplc_pkg::fplc_meta_t meta_s4;
	logic [29:0]          z0_s4;
	logic [29:0]          z1_s4;
	logic [31:0]          total_s4;
	logic [31:0]          total_d;

	assign enable    = !valid_s4 || !out_stall;
	assign req_stall = !enable;

	// dwt plane products, one luma and one chroma lane per level
	always_comb begin
		for (int lv = 0; lv < NL; lv++) begin
			aw[lv]         = 14'(req.aw0 >> (lv + 1));
			aw10[lv]       = {1'b0, aw[lv], 3'b000} + {3'b000, aw[lv], 1'b0} + 18'd7;
			pw[lv]         = 15'(aw10[lv] >> 3);
			ah[lv]         = 14'(req.ah0 >> (lv + 1));
			ahc[lv]        = 14'(req.ah0 >> (lv + 2));
			prod_d[lv]     = {14'd0, pw[lv]} * {15'd0, ah[lv]};
			prod_d[lv+NL]  = {14'd0, pw[lv]} * {15'd0, ahc[lv]};
		end
	end

	// page alignment and pair sums
	always_comb begin
		for (int i = 0; i < 2*NL; i++) begin
			page[i] = (prod_s1[i] + 29'((1 << PB) - 1)) & ~29'((1 << PB) - 1);
		end
		for (int k = 0; k < NL; k++) begin
			pair_d[k] = {1'b0, page[2*k]} + {1'b0, page[2*k+1]};
		end
		z1_d = meta_s1.nv ? (z0_s1 >> 1) : '0;
	end

	// final total
	assign total_d = meta_s3.nv
		? {2'b00, z0_s3} + {2'b00, z1_s3} + {1'b0, quad_s3[0]} + {1'b0, quad_s3[1]}
		: {2'b00, z0_s3};

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (enable) begin
			valid_s1 <= req_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (enable) begin
			meta_s1 <= req.meta;
			z0_s1   <= {14'd0, req.meta.s0} * {16'd0, req.height};
			for (int i = 0; i < 2*NL; i++) begin
				prod_s1[i] <= prod_d[i];
			end

			meta_s2 <= meta_s1;
			z0_s2   <= z0_s1;
			z1_s2   <= z1_d;
			for (int k = 0; k < NL; k++) begin
				pair_s2[k] <= pair_d[k];
			end

			meta_s3    <= meta_s2;
			z0_s3      <= z0_s2;
			z1_s3      <= z1_s2;
			quad_s3[0] <= {1'b0, pair_s2[0]} + {1'b0, pair_s2[1]};
			quad_s3[1] <= {1'b0, pair_s2[2]} + {1'b0, pair_s2[3]};

			meta_s4  <= meta_s3;
			z0_s4    <= z0_s3;
			z1_s4    <= z1_s3;
			total_s4 <= total_d;
		end
	end

	assign out_valid     = valid_s4;
	assign status        = meta_s4.status;
	assign plane_count   = meta_s4.planes;
	assign first_stride  = meta_s4.s0;
	assign second_stride = meta_s4.s1;
	assign first_size    = {2'b00, z0_s4};
	assign second_size   = {2'b00, z1_s4};
	assign total_size    = total_s4;
	assign align_used    = meta_s4.al;

endmodule

/* design/frame_plane_layout_calc_core.sv */
// frame plane layout calculator, top level
// throughput: one request per cycle while nothing stalls; front stage, queue and four back
// stages advance together when no stall holds them, the queue lets the front keep taking requests
// while the back end holds a result for a stalled consumer
// reset: arst_n clears all valid flags and queue pointers, payload is not reset
module frame_plane_layout_calc_core #(
	parameter int QUEUE_DEPTH = fplc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [3:0]  pixel_format,
	input  logic [1:0]  align_select,
	input  logic [13:0] width,
	input  logic [13:0] height,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [1:0]  plane_count,
	output logic [15:0] first_stride,
	output logic [15:0] second_stride,
	output logic [31:0] first_size,
	output logic [31:0] second_size,
	output logic [31:0] total_size,
	output logic [6:0]  align_used
);

	logic                fq_valid;
	logic                fq_stall;
	fplc_pkg::fplc_req_t fq_req;
	logic                qb_valid;
	logic                qb_stall;
	fplc_pkg::fplc_req_t qb_req;

	// request classification
	fplc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.pixel_format (pixel_format),
		.align_select (align_select),
		.width        (width),
		.height       (height),
		.req_valid    (fq_valid),
		.req_stall    (fq_stall),
		.req          (fq_req)
	);

	// decoupling queue
	fplc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_stall (fq_stall),
		.wr_req   (fq_req),
		.rd_valid (qb_valid),
		.rd_stall (qb_stall),
		.rd_req   (qb_req)
	);

	// size arithmetic
	fplc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (qb_valid),
		.req_stall     (qb_stall),
		.req           (qb_req),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.plane_count   (plane_count),
		.first_stride  (first_stride),
		.second_stride (second_stride),
		.first_size    (first_size),
		.second_size   (second_size),
		.total_size    (total_size),
		.align_used    (align_used)
	);

endmodule

/* bench/tb_top.sv */
// testbench for frame_plane_layout_calc_core: directed and random layout requests,
// each result checked field by field against a built-in layout predictor
// depends on fplc_pkg and frame_plane_layout_calc_core
`timescale 1ns / 1ps

module tb_top;

	// pixel format code that no operation supports
	localparam logic [3:0] FMT_RSVD_HI = 4'd15;
	localparam logic [13:0] DIM_MAX    = 14'd16383;

	localparam int RANDOM_REQS  = 1450;
	localparam int IDLE_PCT     = 25;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 80;
	localparam int CALM_LO      = 800;
	localparam int CALM_HI      = 1100;
	localparam int DRAIN_CYCLES = 12;
	localparam int STUCK_LIMIT  = 2000;

	typedef struct {
		logic        op;
		logic [3:0]  fmt;
		logic [1:0]  sel;
		logic [13:0] w;
		logic [13:0] h;
	} layout_req_t;

	typedef struct {
		logic        status;
		logic [1:0]  planes;
		logic [15:0] s0;
		logic [15:0] s1;
		logic [31:0] z0;
		logic [31:0] z1;
		logic [31:0] total;
		logic [6:0]  al;
	} plane_layout_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = fplc_pkg::OP_NORMAL;
	logic [3:0]  pixel_format = fplc_pkg::FMT_NV12;
	logic [1:0]  align_select = fplc_pkg::ALIGN_DEFAULT;
	logic [13:0] width = '0;
	logic [13:0] height = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        status;
	logic [1:0]  plane_count;
	logic [15:0] first_stride;
	logic [15:0] second_stride;
	logic [31:0] first_size;
	logic [31:0] second_size;
	logic [31:0] total_size;
	logic [6:0]  align_used;

	layout_req_t   req_backlog[$];
	plane_layout_t layout_due[$];
	layout_req_t   cur_req;

	int n_issued = 0;
	int n_checked = 0;
	int n_rejected = 0;
	int n_two_plane = 0;
	int n_raw = 0;
	int n_errors = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int stuck_cycles = 0;

	frame_plane_layout_calc_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.pixel_format (pixel_format),
		.align_select (align_select),
		.width        (width),
		.height       (height),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.plane_count  (plane_count),
		.first_stride (first_stride),
		.second_stride(second_stride),
		.first_size   (first_size),
		.second_size  (second_size),
		.total_size   (total_size),
		.align_used   (align_used)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned round_up(int unsigned v, int unsigned a);
		return (v + a - 1) & ~(a - 1);
	endfunction

	function automatic int unsigned div_up(int unsigned v, int unsigned d);
		return (v + d - 1) / d;
	endfunction

	// bytes of all dwt planes: four levels, luma and half-height chroma, 4 KiB pages
	function automatic int unsigned dwt_bytes(int unsigned w, int unsigned h);
		int unsigned sum;
		int unsigned lw;
		int unsigned lh;
		int unsigned row;
		sum = 0;
		for (int lv = 1; lv <= fplc_pkg::DWT_LEVELS; lv++) begin
			lw  = round_up(w, fplc_pkg::DWT_W_ALIGN) >> lv;
			lh  = round_up(h, fplc_pkg::DWT_H_ALIGN) >> lv;
			row = (lw * 10 + 7) / 8;
			sum += round_up(row * lh, 1 << fplc_pkg::DWT_PAGE_BITS);
			sum += round_up(row * (lh / 2), 1 << fplc_pkg::DWT_PAGE_BITS);
		end
		return sum;
	endfunction

	// expected plane layout of one request
	function automatic plane_layout_t compute_layout(layout_req_t r);
		plane_layout_t p;
		int unsigned   al;
		int unsigned   stride;
		int unsigned   s0;
		p  = '{default: '0};
		s0 = 0;
		p.planes = 2'd1;
		if (r.op == fplc_pkg::OP_NORMAL) begin
			al = (r.sel == fplc_pkg::ALIGN_THIRTY2) ? 32'(fplc_pkg::ALIGN_VAL_32) :
			     (r.sel == fplc_pkg::ALIGN_SIXTY4) ? 32'(fplc_pkg::ALIGN_VAL_64) :
			     32'(fplc_pkg::ALIGN_VAL_16);
			stride = round_up(32'(r.w), al);
			p.al = al[6:0];
			case (r.fmt)
				fplc_pkg::FMT_NV12, fplc_pkg::FMT_NV21: begin
					p.planes = 2'd2;
					s0 = stride;
					p.s1 = stride[15:0];
				end
				fplc_pkg::FMT_RGB565, fplc_pkg::FMT_BAYER10, fplc_pkg::FMT_BAYER12,
				fplc_pkg::FMT_BAYER14, fplc_pkg::FMT_UYVY, fplc_pkg::FMT_YUYV,
				fplc_pkg::FMT_YVYU, fplc_pkg::FMT_VYUY: s0 = stride * 2;
				fplc_pkg::FMT_RGB888: s0 = stride * 3;
				fplc_pkg::FMT_BAYER8: s0 = stride;
				fplc_pkg::FMT_RAW10P: s0 = div_up(32'(r.w), 4) * 5;
				default: p.status = 1'b1;
			endcase
			if (p.planes == 2'd2) begin
				p.z0    = s0 * 32'(r.h);
				p.z1    = p.z0 / 2;
				p.total = p.z0 + p.z1 + dwt_bytes(32'(r.w), 32'(r.h));
			end else begin
				p.z0    = s0 * 32'(r.h);
				p.total = p.z0;
			end
		end else begin
			case (r.fmt)
				fplc_pkg::FMT_BAYER8:  s0 = 32'(r.w);
				fplc_pkg::FMT_BAYER10: s0 = div_up(32'(r.w), 12) * 16;
				fplc_pkg::FMT_BAYER12: s0 = div_up(32'(r.w), 10) * 16;
				fplc_pkg::FMT_BAYER14: s0 = 32'(r.w) * 2;
				fplc_pkg::FMT_RAW10P:  s0 = div_up(32'(r.w), 4) * 5;
				default:               p.status = 1'b1;
			endcase
			p.z0    = s0 * 32'(r.h);
			p.total = p.z0;
		end
		p.s0 = s0[15:0];
		// unsupported format clears every other field
		if (p.status)
			p = '{status: 1'b1, default: '0};
		return p;
	endfunction

	task automatic queue_req(logic op, logic [3:0] fmt, logic [1:0] sel,
	                         logic [13:0] w, logic [13:0] h);
		layout_req_t r;
		r = '{op: op, fmt: fmt, sel: sel, w: w, h: h};
		req_backlog.push_back(r);
	endtask

	// dimension mix: mostly small, some near the top, some alignment edges
	function automatic logic [13:0] pick_dim();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 55)
			return 14'($urandom_range(0, 1500));
		else if (k < 70)
			return 14'($urandom_range(16000, 32'(DIM_MAX)));
		else if (k < 82)
			return 14'(64 * $urandom_range(0, 255) + $urandom_range(0, 2) - 1);
		else
			return 14'($urandom);
	endfunction

	// random request: mostly supported formats, some unsupported ones
	function automatic layout_req_t pick_req();
		layout_req_t r;
		r.op  = ($urandom_range(0, 99) < 30) ? fplc_pkg::OP_RAW : fplc_pkg::OP_NORMAL;
		r.sel = 2'($urandom);
		if ($urandom_range(0, 99) < 12)
			r.fmt = 4'($urandom);
		else if (r.op == fplc_pkg::OP_RAW)
			r.fmt = 4'($urandom_range(32'(fplc_pkg::FMT_BAYER8),
			                          32'(fplc_pkg::FMT_RAW10P)));
		else
			r.fmt = 4'($urandom_range(32'(fplc_pkg::FMT_NV12), 32'(fplc_pkg::FMT_VYUY)));
		r.w = pick_dim();
		r.h = pick_dim();
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				layout_due.push_back(compute_layout(cur_req));
				n_issued++;
				if (cur_req.op == fplc_pkg::OP_RAW)
					n_raw++;
			end
			if (!in_valid || !in_stall) begin
				if (req_backlog.size() != 0 &&
				    ((n_issued >= CALM_LO && n_issued < CALM_HI) ||
				     $urandom_range(0, 99) >= IDLE_PCT)) begin
					cur_req = req_backlog.pop_front();
					operation    <= cur_req.op;
					pixel_format <= cur_req.fmt;
					align_select <= cur_req.sel;
					width        <= cur_req.w;
					height       <= cur_req.h;
					in_valid     <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and consumer stall
	always @(posedge clk or negedge arst_n) begin
		plane_layout_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (layout_due.size() == 0) begin
					$error("result with no request outstanding");
					n_errors++;
				end else begin
					want = layout_due.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("plane_count", 32'(want.planes), 32'(plane_count));
					check_field("first_stride", 32'(want.s0), 32'(first_stride));
					check_field("second_stride", 32'(want.s1), 32'(second_stride));
					check_field("first_size", want.z0, first_size);
					check_field("second_size", want.z1, second_size);
					check_field("total_size", want.total, total_size);
					check_field("align_used", 32'(want.al), 32'(align_used));
					if (want.status)
						n_rejected++;
					if (want.planes == 2'd2)
						n_two_plane++;
				end
				n_checked++;
			end
			// one long hold-off so the pipeline backs up into the input
			if (!hold_done && n_checked == HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (n_checked >= CALM_LO && n_checked < CALM_HI) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", STUCK_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		int k;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// normal mode: every format code, every alignment, extreme sizes
		for (int f = 0; f < 16; f++) begin
			queue_req(fplc_pkg::OP_NORMAL, 4'(f), 2'(f % 4),
			          (f == 0) ? 14'd0 : (f % 3 == 1) ? DIM_MAX : 14'($urandom_range(1, 999)),
			          (f == 0) ? 14'd0 : (f % 3 == 2) ? DIM_MAX : 14'($urandom_range(1, 999)));
		end
		// raw dump: each packing, maximum width, and unsupported formats
		queue_req(fplc_pkg::OP_RAW, fplc_pkg::FMT_NV12, fplc_pkg::ALIGN_SIXTY4,
		          DIM_MAX, DIM_MAX);
		queue_req(fplc_pkg::OP_RAW, fplc_pkg::FMT_BAYER8, fplc_pkg::ALIGN_THIRTY2,
		          DIM_MAX, DIM_MAX);
		queue_req(fplc_pkg::OP_RAW, fplc_pkg::FMT_BAYER10, fplc_pkg::ALIGN_SIXTY4,
		          DIM_MAX, 14'($urandom_range(1, 999)));
		queue_req(fplc_pkg::OP_RAW, fplc_pkg::FMT_BAYER10, fplc_pkg::ALIGN_DEFAULT,
		          14'd13, 14'd7);
		queue_req(fplc_pkg::OP_RAW, fplc_pkg::FMT_BAYER12, fplc_pkg::ALIGN_SIXTY4,
		          DIM_MAX, DIM_MAX);
		queue_req(fplc_pkg::OP_RAW, fplc_pkg::FMT_BAYER14, fplc_pkg::ALIGN_SIXTEEN,
		          DIM_MAX, DIM_MAX);
		queue_req(fplc_pkg::OP_RAW, fplc_pkg::FMT_RAW10P, fplc_pkg::ALIGN_SIXTY4,
		          14'd0, 14'd0);
		queue_req(fplc_pkg::OP_RAW, fplc_pkg::FMT_VYUY, fplc_pkg::ALIGN_DEFAULT,
		          14'd640, 14'd480);
		queue_req(fplc_pkg::OP_RAW, FMT_RSVD_HI, fplc_pkg::ALIGN_SIXTY4, DIM_MAX, DIM_MAX);

		// sender pause: let every outstanding result come back
		while (req_backlog.size() != 0 || in_valid || layout_due.size() != 0)
			@(posedge clk);

		@(negedge clk);
		for (k = 0; k < RANDOM_REQS; k++)
			req_backlog.push_back(pick_req());

		while (req_backlog.size() != 0 || in_valid || layout_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d requests (%0d raw dump, %0d two-plane, %0d rejected formats)",
		         n_issued, n_raw, n_two_plane, n_rejected);
		$display("%0d results checked against the layout predictor", n_checked);
		if (n_errors == 0 && layout_due.size() == 0 && n_checked == n_issued)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
